[rtl/first_fit_heap_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_macros.svh
// Assertion helpers used by the allocator top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, gated by reset
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the heap allocator controller and datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MIN_CHUNK   = 8;
  localparam int ALIGN_BYTES = 4;
  localparam int HDR_BYTES   = 8;

  localparam logic [16:0] LINK_END   = 17'h1FFFF;
  localparam logic [16:0] MAX17      = 17'h1FFFF;
  localparam logic [16:0] HEAP_RESET = 17'h10000;

  localparam logic [1:0] REG_HEAP_SIZE = 2'd0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_START,
    DP_RD_CUR,
    DP_RD_H,
    DP_A_STEP,
    DP_A_EXACT,
    DP_A_SPLIT1,
    DP_A_SPLIT2,
    DP_F_HS,
    DP_F_STEP,
    DP_F_BOTH,
    DP_F_PREV,
    DP_F_NEXT1,
    DP_F_LINK1,
    DP_F_PUT,
    DP_INIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_A_EV,
    S_A_SPLIT2,
    S_F_CHK,
    S_F_HS,
    S_F_WALK,
    S_F_WEV,
    S_F_MRG,
    S_F_PUT,
    S_INIT
  } ctrl_state_t;

  typedef struct packed {
    logic req_zero;
    logic fo_low;
    logic cur_end;
    logic step_lim;
    logic fit_exact;
    logic fit_split;
    logic cur_le_h;
    logic mprev;
    logic mnext;
  } dp_flags_t;

endpackage

[rtl/ffha_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dp
// Header stores, list pointers and usage counters, stepped by micro-ops.
// ----------------------------------------------------------------------------
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_op_t      op,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_free_offset,
  input  logic [16:0] heap_size,
  output dp_flags_t   flags,
  output logic [15:0] data_offset,
  output logic [16:0] used_bytes,
  output logic [16:0] total_bytes
);

  localparam int DEPTH  = HEAP_BYTES / 4;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int STEP_W = IDX_W + 1;
  localparam logic [STEP_W-1:0] WALK_LIMIT = STEP_W'(DEPTH + 1);

  function automatic logic [IDX_W-1:0] idx_of(input logic [16:0] off);
    logic [IDX_W+14:0] t;
    t = {{IDX_W{1'b0}}, off[16:2]};
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? MAX17 : s[16:0];
  endfunction

  function automatic logic [16:0] sat_sub(input logic [16:0] a, input logic [16:0] b);
    return (b > a) ? 17'd0 : a - b;
  endfunction

  logic [16:0] size_mem [DEPTH];
  logic [16:0] link_mem [DEPTH];

  logic [16:0] cur_r, cur_nxt, prev_r, prev_nxt, h_r, h_nxt;
  logic [16:0] hs_r, hs_nxt, psz_r, psz_nxt, sz_r, sz_nxt;
  logic [17:0] need_r, need_nxt;
  logic        head_r, head_nxt, req_zero_r, req_zero_nxt, fo_low_r, fo_low_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [16:0] first_free_r, first_free_nxt, used_r, used_nxt, gross_r, gross_nxt;
  logic [15:0] data_r, data_nxt;
  logic        e0sz_r, e0sz_nxt, e0lk_r, e0lk_nxt;
  logic        hitsz_r, hitlk_r;
  logic [16:0] rsz_q, rlk_q, rsz, rlk;

  logic             rd_en, sz_we, lk_we;
  logic [IDX_W-1:0] rd_idx, sz_idx, lk_idx;
  logic [16:0]      sz_wd, lk_wd;

  logic [17:0] rq, rnd;
  logic [16:0] init_h, sec;
  logic [16:0] hs_net;

  assign rsz = hitsz_r ? HEAP_RESET : rsz_q;
  assign rlk = hitlk_r ? LINK_END : rlk_q;
  assign sec = 17'({1'b0, cur_r} + need_r);
  assign hs_net = (hs_r < 17'(HDR_BYTES)) ? 17'd0 : hs_r - 17'(HDR_BYTES);

  always_comb begin
    rq = ({2'b0, in_request_size} < 18'(MIN_CHUNK)) ? 18'(MIN_CHUNK)
                                                    : {2'b0, in_request_size};
    rnd = ((rq + 18'(ALIGN_BYTES - 1)) / 18'(ALIGN_BYTES)) * 18'(ALIGN_BYTES);
    init_h = heap_size & ~17'd3;
    if ({8'b0, init_h} > 25'(HEAP_BYTES)) begin
      init_h = 17'(HEAP_BYTES);
    end
  end

  always_comb begin
    flags.req_zero  = req_zero_r;
    flags.fo_low    = fo_low_r;
    flags.cur_end   = (cur_r == LINK_END);
    flags.step_lim  = (steps_r >= WALK_LIMIT);
    flags.fit_exact = (need_r == {1'b0, rsz});
    flags.fit_split = ({1'b0, sz_r} + 18'(2 * HDR_BYTES)) < {1'b0, rsz};
    flags.cur_le_h  = (cur_r <= h_r);
    flags.mprev     = !head_r && (({1'b0, prev_r} + {1'b0, psz_r}) == {1'b0, h_r});
    flags.mnext     = ({1'b0, h_r} + {1'b0, hs_r}) == {1'b0, cur_r};
  end

  always_comb begin
    cur_nxt = cur_r;   prev_nxt = prev_r;   h_nxt = h_r;
    hs_nxt = hs_r;     psz_nxt = psz_r;     sz_nxt = sz_r;
    need_nxt = need_r; head_nxt = head_r;   steps_nxt = steps_r;
    req_zero_nxt = req_zero_r;  fo_low_nxt = fo_low_r;
    first_free_nxt = first_free_r;
    used_nxt = used_r; gross_nxt = gross_r; data_nxt = data_r;
    rd_en = 1'b0;  rd_idx = idx_of(cur_r);
    sz_we = 1'b0;  sz_idx = idx_of(cur_r);  sz_wd = need_r[16:0];
    lk_we = 1'b0;  lk_idx = idx_of(prev_r); lk_wd = rlk;
    case (op)
      DP_START: begin
        sz_nxt = rnd[16:0];
        need_nxt = rnd + 18'(HDR_BYTES);
        req_zero_nxt = (in_request_size == 16'd0);
        fo_low_nxt = (in_free_offset < 16'(HDR_BYTES));
        h_nxt = {1'b0, in_free_offset - 16'(HDR_BYTES)};
        cur_nxt = first_free_r;
        prev_nxt = 17'd0;
        head_nxt = 1'b1;
        steps_nxt = '0;
        data_nxt = 16'd0;
      end
      DP_RD_CUR: begin
        rd_en = 1'b1;
      end
      DP_RD_H: begin
        rd_en = 1'b1;
        rd_idx = idx_of(h_r);
      end
      DP_A_STEP: begin
        prev_nxt = cur_r;
        cur_nxt = rlk;
        head_nxt = 1'b0;
        steps_nxt = steps_r + 1'b1;
      end
      DP_A_EXACT: begin
        if (head_r) begin
          first_free_nxt = rlk;
        end else begin
          lk_we = 1'b1;
        end
        data_nxt = 16'(cur_r + 17'(HDR_BYTES));
        used_nxt = sat_add(used_r, sz_r);
        gross_nxt = sat_add(gross_r, need_r[16:0]);
      end
      DP_A_SPLIT1: begin
        sz_we = 1'b1;
        sz_idx = idx_of(sec);
        sz_wd = 17'({1'b0, rsz} - need_r);
        lk_we = 1'b1;
        lk_idx = idx_of(sec);
        lk_wd = rlk;
      end
      DP_A_SPLIT2: begin
        if (head_r) begin
          first_free_nxt = sec;
        end else begin
          lk_we = 1'b1;
          lk_wd = sec;
        end
        sz_we = 1'b1;
        data_nxt = 16'(cur_r + 17'(HDR_BYTES));
        used_nxt = sat_add(used_r, sz_r);
        gross_nxt = sat_add(gross_r, need_r[16:0]);
      end
      DP_F_HS: begin
        hs_nxt = rsz;
      end
      DP_F_STEP: begin
        prev_nxt = cur_r;
        psz_nxt = rsz;
        cur_nxt = rlk;
        head_nxt = 1'b0;
        steps_nxt = steps_r + 1'b1;
      end
      DP_F_BOTH: begin
        lk_we = 1'b1;
        sz_we = 1'b1;
        sz_idx = idx_of(prev_r);
        sz_wd = psz_r + hs_r + rsz;
        used_nxt = sat_sub(used_r, hs_net);
        gross_nxt = sat_sub(gross_r, hs_r);
      end
      DP_F_PREV: begin
        sz_we = 1'b1;
        sz_idx = idx_of(prev_r);
        sz_wd = psz_r + hs_r;
        used_nxt = sat_sub(used_r, hs_net);
        gross_nxt = sat_sub(gross_r, hs_r);
      end
      DP_F_NEXT1: begin
        sz_we = 1'b1;
        sz_idx = idx_of(h_r);
        sz_wd = hs_r + rsz;
        lk_we = 1'b1;
        lk_idx = idx_of(h_r);
      end
      DP_F_LINK1: begin
        lk_we = 1'b1;
        lk_idx = idx_of(h_r);
        lk_wd = cur_r;
      end
      DP_F_PUT: begin
        if (head_r) begin
          first_free_nxt = h_r;
        end else begin
          lk_we = 1'b1;
          lk_wd = h_r;
        end
        used_nxt = sat_sub(used_r, hs_net);
        gross_nxt = sat_sub(gross_r, hs_r);
      end
      DP_INIT: begin
        first_free_nxt = 17'd0;
        sz_we = 1'b1;
        sz_idx = '0;
        sz_wd = init_h;
        lk_we = 1'b1;
        lk_idx = '0;
        lk_wd = LINK_END;
        used_nxt = 17'd0;
        gross_nxt = 17'd0;
      end
      default: begin
      end
    endcase
    // entry zero stops reading as its reset value once written
    e0sz_nxt = e0sz_r && !(sz_we && sz_idx == '0);
    e0lk_nxt = e0lk_r && !(lk_we && lk_idx == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_free_r <= 17'd0;
      used_r <= 17'd0;
      gross_r <= 17'd0;
      e0sz_r <= 1'b1;
      e0lk_r <= 1'b1;
      hitsz_r <= 1'b0;
      hitlk_r <= 1'b0;
    end else begin
      first_free_r <= first_free_nxt;
      used_r <= used_nxt;
      gross_r <= gross_nxt;
      e0sz_r <= e0sz_nxt;
      e0lk_r <= e0lk_nxt;
      if (rd_en) begin
        hitsz_r <= e0sz_r && (rd_idx == '0);
        hitlk_r <= e0lk_r && (rd_idx == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;   prev_r <= prev_nxt;   h_r <= h_nxt;
    hs_r <= hs_nxt;     psz_r <= psz_nxt;     sz_r <= sz_nxt;
    need_r <= need_nxt; head_r <= head_nxt;   steps_r <= steps_nxt;
    req_zero_r <= req_zero_nxt;  fo_low_r <= fo_low_nxt;
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rsz_q <= size_mem[rd_idx];
      rlk_q <= link_mem[rd_idx];
    end
    if (sz_we) begin
      size_mem[sz_idx] <= sz_wd;
    end
    if (lk_we) begin
      link_mem[lk_idx] <= lk_wd;
    end
  end

  assign data_offset = data_r;
  assign used_bytes  = used_r;
  assign total_bytes = gross_r;

endmodule

[rtl/ffha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate, free, init and no-op; drives one datapath micro-op a cycle.
// ----------------------------------------------------------------------------
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] in_opcode,
  input  dp_flags_t flags,
  output dp_op_t    op,
  output logic      busy,
  output logic      out_valid,
  output status_t   out_status
);

  ctrl_state_t state_r, state_nxt;
  logic        valid_r, valid_nxt;
  status_t     status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    status_nxt = status_r;
    op = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op = DP_START;
          case (opcode_t'(in_opcode))
            OP_ALLOC: state_nxt = S_A_CHK;
            OP_FREE:  state_nxt = S_F_CHK;
            OP_INIT:  state_nxt = S_INIT;
            default: begin
              valid_nxt = 1'b1;
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_A_CHK: begin
        if (flags.req_zero) begin
          valid_nxt = 1'b1; status_nxt = ST_ZERO; state_nxt = S_IDLE;
        end else if (flags.cur_end || flags.step_lim) begin
          valid_nxt = 1'b1; status_nxt = ST_NOFIT; state_nxt = S_IDLE;
        end else begin
          op = DP_RD_CUR;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        if (flags.fit_exact) begin
          op = DP_A_EXACT;
          valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
        end else if (flags.fit_split) begin
          op = DP_A_SPLIT1;
          state_nxt = S_A_SPLIT2;
        end else begin
          op = DP_A_STEP;
          state_nxt = S_A_CHK;
        end
      end
      S_A_SPLIT2: begin
        op = DP_A_SPLIT2;
        valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
      end
      S_F_CHK: begin
        if (flags.fo_low) begin
          valid_nxt = 1'b1; status_nxt = ST_NOFIT; state_nxt = S_IDLE;
        end else begin
          op = DP_RD_H;
          state_nxt = S_F_HS;
        end
      end
      S_F_HS: begin
        op = DP_F_HS;
        state_nxt = S_F_WALK;
      end
      S_F_WALK: begin
        if (!flags.cur_end && flags.cur_le_h) begin
          if (flags.step_lim) begin
            valid_nxt = 1'b1; status_nxt = ST_NOFIT; state_nxt = S_IDLE;
          end else begin
            op = DP_RD_CUR;
            state_nxt = S_F_WEV;
          end
        end else if (!flags.cur_end) begin
          op = DP_RD_CUR;
          state_nxt = S_F_MRG;
        end else if (flags.mprev) begin
          // tail chunk adjacent to the last free chunk: grow it
          op = DP_F_PREV;
          valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
        end else begin
          op = DP_F_LINK1;
          state_nxt = S_F_PUT;
        end
      end
      S_F_WEV: begin
        op = DP_F_STEP;
        state_nxt = S_F_WALK;
      end
      S_F_MRG: begin
        if (flags.mprev && flags.mnext) begin
          op = DP_F_BOTH;
          valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
        end else if (flags.mprev) begin
          op = DP_F_PREV;
          valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
        end else if (flags.mnext) begin
          op = DP_F_NEXT1;
          state_nxt = S_F_PUT;
        end else begin
          op = DP_F_LINK1;
          state_nxt = S_F_PUT;
        end
      end
      S_F_PUT: begin
        op = DP_F_PUT;
        valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
      end
      S_INIT: begin
        op = DP_INIT;
        valid_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_status = status_r;

endmodule

[rtl/first_fit_heap_allocator_unit.sv]
`timescale 1ns / 1ps
// Allocate walks the free list from its head, reading each header visited, until it
// finds an exact fit or a chunk to split, or reaches the end; free reads the freed
// header, walks the free headers below the chunk, then merges or links it in. One item
// at a time: a new command is accepted only while idle. The receiver cannot stall.
// Reset is synchronous; no clearing pass, entry zero of the header store reads as one
// 65536-byte chunk until first written.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over an address-ordered, coalescing free list.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_unit_macros.svh"

module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_free_offset,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_data_offset,
  output logic [16:0] out_used_bytes,
  output logic [16:0] out_total_bytes,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [16:0] heap_size_r;
  dp_flags_t   flags;
  dp_op_t      op;
  status_t     status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_HEAP_SIZE) begin
      heap_size_r <= cfg_pwdata[16:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_HEAP_SIZE) ? {15'd0, heap_size_r} : 32'd0;

  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_opcode  (in_opcode),
    .flags      (flags),
    .op         (op),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (status)
  );

  ffha_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .in_request_size (in_request_size),
    .in_free_offset  (in_free_offset),
    .heap_size       (heap_size_r),
    .flags           (flags),
    .data_offset     (out_data_offset),
    .used_bytes      (out_used_bytes),
    .total_bytes     (out_total_bytes)
  );

  assign out_status = status;

  `FFHA_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid, "accepted beat neither started nor finished")
  `FFHA_ASSERT_NOW(a_fail_no_offset, clk, rst_n, out_valid && out_status != ST_OK, out_data_offset == 16'd0, "failed beat carries an offset")
  `FFHA_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy, "result beat while still sequencing")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate, free, init and no-op commands into the first-fit heap
// allocator, resizes the heap between phases through the APB port, and checks
// every result beat against an in-bench model of the free list and counters.
// ----------------------------------------------------------------------------
module tb_top;
  import ffha_pkg::*;

  localparam int unsigned SLOTS      = 16384;
  localparam int unsigned HEAP_MAX   = 65536;
  localparam int unsigned WALK_LIM   = SLOTS + 1;
  localparam int unsigned CYCLE_CAP  = 30000000;
  localparam int          RAND_ITEMS = 1250;

  // live pick: any chunk, the oldest, the newest
  localparam int PICK_ANY    = 0;
  localparam int PICK_OLDEST = 1;
  localparam int PICK_NEWEST = 2;

  typedef struct {
    opcode_t     op;
    logic [15:0] req;
    logic [15:0] fo;
    bit          pick_live;
    int          pick;
    bit          drain;
  } cmd_t;

  typedef struct {
    status_t     st;
    logic [15:0] off;
    logic [16:0] used;
    logic [16:0] gross;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = '0;
  logic [15:0] in_request_size = '0;
  logic [15:0] in_free_offset = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_data_offset;
  logic [16:0] out_used_bytes;
  logic [16:0] out_total_bytes;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  first_fit_heap_allocator_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- heap model ----------------
  logic [16:0] chunk_size[SLOTS];
  logic [16:0] chunk_link[SLOTS];
  logic [16:0] free_head;
  logic [16:0] used_sum;
  logic [16:0] gross_sum;
  logic [16:0] heap_cfg;
  int unsigned live_offs[$];

  function automatic int unsigned slot(int unsigned off);
    return (off >> 2) % SLOTS;
  endfunction

  function automatic void set_link(bit at_head, int unsigned prev, int unsigned v);
    if (at_head) free_head = v[16:0];
    else chunk_link[slot(prev)] = v[16:0];
  endfunction

  function automatic logic [16:0] sat_add(int unsigned a, int unsigned b);
    return (a + b > MAX17) ? MAX17 : 17'(a + b);
  endfunction

  function automatic logic [16:0] sat_sub(int unsigned a, int unsigned b);
    return (b > a) ? 17'd0 : 17'(a - b);
  endfunction

  function automatic status_t heap_alloc(int unsigned req, output logic [15:0] off);
    int unsigned sz, need, s, nx, sec;
    int unsigned prev = 0, cur = free_head, steps = 0;
    bit          at_head = 1'b1;
    off = '0;
    if (req == 0) return ST_ZERO;
    sz   = (req < MIN_CHUNK) ? MIN_CHUNK : req;
    sz   = (sz + 3) & ~32'd3;
    need = sz + HDR_BYTES;
    while (cur != LINK_END && steps < WALK_LIM) begin
      s  = chunk_size[slot(cur)];
      nx = chunk_link[slot(cur)];
      if (need == s || sz + 2 * HDR_BYTES < s) begin
        if (need == s) begin
          set_link(at_head, prev, nx);
        end else begin
          sec = cur + need;
          chunk_size[slot(sec)] = 17'(s - need);
          chunk_link[slot(sec)] = nx[16:0];
          set_link(at_head, prev, sec);
          chunk_size[slot(cur)] = 17'(need);
        end
        off       = 16'(cur + HDR_BYTES);
        used_sum  = sat_add(used_sum, sz);
        gross_sum = sat_add(gross_sum, need);
        return ST_OK;
      end
      at_head = 1'b0;
      prev    = cur;
      cur     = nx;
      steps++;
    end
    return ST_NOFIT;
  endfunction

  function automatic status_t heap_release(int unsigned fo);
    int unsigned h, hs, ns, nl, psz;
    int unsigned prev = 0, nxt = free_head, steps = 0;
    bit          at_head = 1'b1, mprev, mnext;
    if (fo < HDR_BYTES) return ST_NOFIT;
    h  = fo - HDR_BYTES;
    hs = chunk_size[slot(h)];
    while (nxt != LINK_END && nxt <= h) begin
      if (steps >= WALK_LIM) return ST_NOFIT;
      at_head = 1'b0;
      prev    = nxt;
      nxt     = chunk_link[slot(nxt)];
      steps++;
    end
    psz   = chunk_size[slot(prev)];
    mprev = !at_head && (prev + psz == h);
    if (nxt != LINK_END) begin
      ns    = chunk_size[slot(nxt)];
      nl    = chunk_link[slot(nxt)];
      mnext = (h + hs == nxt);
      if (mprev && mnext) begin
        chunk_link[slot(prev)] = nl[16:0];
        chunk_size[slot(prev)] = 17'(psz + hs + ns);
      end else if (mprev) begin
        chunk_size[slot(prev)] = 17'(psz + hs);
      end else if (mnext) begin
        chunk_size[slot(h)] = 17'(hs + ns);
        chunk_link[slot(h)] = nl[16:0];
        set_link(at_head, prev, h);
      end else begin
        chunk_link[slot(h)] = nxt[16:0];
        set_link(at_head, prev, h);
      end
    end else if (mprev) begin
      chunk_size[slot(prev)] = 17'(psz + hs);
    end else begin
      chunk_link[slot(h)] = LINK_END;
      set_link(at_head, prev, h);
    end
    used_sum  = sat_sub(used_sum, (hs < HDR_BYTES) ? 0 : hs - HDR_BYTES);
    gross_sum = sat_sub(gross_sum, hs);
    return ST_OK;
  endfunction

  function automatic resp_t heap_apply(cmd_t c);
    resp_t       r;
    int unsigned hsz;
    r.st  = ST_OK;
    r.off = '0;
    case (c.op)
      OP_ALLOC: begin
        r.st = heap_alloc(c.req, r.off);
        if (r.st == ST_OK) live_offs.push_back(r.off);
      end
      OP_FREE: begin
        r.st = heap_release(c.fo);
        if (r.st == ST_OK)
          foreach (live_offs[i])
            if (live_offs[i] == c.fo) begin
              live_offs.delete(i);
              break;
            end
      end
      OP_INIT: begin
        hsz = heap_cfg & ~32'd3;
        if (hsz > HEAP_MAX) hsz = HEAP_MAX;
        free_head     = '0;
        chunk_size[0] = 17'(hsz);
        chunk_link[0] = LINK_END;
        used_sum      = '0;
        gross_sum     = '0;
        live_offs.delete();
      end
      default: ;
    endcase
    r.used  = used_sum;
    r.gross = gross_sum;
    return r;
  endfunction

  initial begin
    foreach (chunk_size[i]) begin
      chunk_size[i] = '0;
      chunk_link[i] = '0;
    end
    heap_cfg      = HEAP_RESET;
    chunk_size[0] = HEAP_RESET;
    chunk_link[0] = LINK_END;
    free_head     = '0;
    used_sum      = '0;
    gross_sum     = '0;
  end

  // ---------------- driver ----------------
  cmd_t        cmd_q[$];
  resp_t       resp_q[$];
  cmd_t        cur_cmd;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int          burst_left = 4;
  int          gap_left = 0;
  int          err_cnt = 0;

  always @(posedge clk) begin : drive
    cmd_t c;
    bit   taken;
    int   k;
    taken = start && !busy;
    if (taken) begin
      resp_q.push_back(heap_apply(cur_cmd));
      n_sent <= n_sent + 1;
    end
    if (rst_n && !(start && !taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (cmd_q.size() > 0 &&
                   (!cmd_q[0].drain || (!start && n_sent == n_seen))) begin
        c = cmd_q.pop_front();
        if (c.pick_live) begin
          if (live_offs.size() == 0) begin
            c.fo = 16'($urandom_range(0, 7));
          end else begin
            case (c.pick)
              PICK_OLDEST: k = 0;
              PICK_NEWEST: k = live_offs.size() - 1;
              default:     k = $urandom_range(0, live_offs.size() - 1);
            endcase
            c.fo = 16'(live_offs[k]);
          end
        end
        cur_cmd         = c;
        in_opcode       <= c.op;
        in_request_size <= c.req;
        in_free_offset  <= c.fo;
        start           <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int unsigned cycles = 0;

  always @(posedge clk) begin : watch
    resp_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: errors");
      $finish;
    end else if (rst_n && out_valid) begin
      n_seen <= n_seen + 1;
      if (resp_q.size() == 0) begin
        $error("result beat with nothing pending");
        err_cnt++;
      end else begin
        e = resp_q.pop_front();
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status);
          err_cnt++;
        end
        if (out_data_offset !== e.off) begin
          $error("data_offset exp %0d got %0d", e.off, out_data_offset);
          err_cnt++;
        end
        if (out_used_bytes !== e.used) begin
          $error("used_bytes exp %0d got %0d", e.used, out_used_bytes);
          err_cnt++;
        end
        if (out_total_bytes !== e.gross) begin
          $error("total_bytes exp %0d got %0d", e.gross, out_total_bytes);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic cmd_t mk(opcode_t op, int unsigned req = 0, int unsigned fo = 0,
                              bit pick_live = 0, int pick = PICK_ANY);
    cmd_t c;
    c.op        = op;
    c.req       = 16'(req);
    c.fo        = 16'(fo);
    c.pick_live = pick_live;
    c.pick      = pick;
    c.drain     = 1'b0;
    return c;
  endfunction

  function automatic int unsigned rand_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return 0;
    if (r < 20) return $urandom_range(1, 8);
    if (r < 80) return $urandom_range(1, 512);
    if (r < 95) return $urandom_range(1, 8192);
    return $urandom_range(0, 65535);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    c = mk(OP_ALLOC, rand_req(), $urandom_range(0, 65535));
    if (r >= 48 && r < 90) begin
      c.op        = OP_FREE;
      c.pick_live = 1'b1;
    end else if (r >= 90 && r < 93) begin
      c.op = OP_FREE;
      c.fo = 16'($urandom_range(0, 7));
    end else if (r >= 93 && r < 96) begin
      c.op = OP_NONE;
    end else if (r >= 96) begin
      c.op = OP_INIT;
    end
    c.drain = ($urandom_range(0, 99) == 0);
    return c;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || n_sent != n_seen);
  endtask

  task automatic cfg_write(logic [1:0] addr, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == REG_HEAP_SIZE) heap_cfg = val[16:0];
  endtask

  int heap_plan[5] = '{16, 1003, 300, 4096, 65536};

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // edge cases on the reset heap
    cmd_q.push_back(mk(OP_ALLOC, 0));
    cmd_q.push_back(mk(OP_ALLOC, 1));
    cmd_q.push_back(mk(OP_ALLOC, 8));
    cmd_q.push_back(mk(OP_ALLOC, 65535));
    cmd_q.push_back(mk(OP_NONE, 65535, 65535));
    cmd_q.push_back(mk(OP_FREE, 0, 0));
    cmd_q.push_back(mk(OP_FREE, 0, 7));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_NEWEST));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_NEWEST));
    // three neighbors, freed so the middle one merges both ways
    cmd_q.push_back(mk(OP_INIT));
    cmd_q.push_back(mk(OP_ALLOC, 40000));
    cmd_q.push_back(mk(OP_ALLOC, 100));
    cmd_q.push_back(mk(OP_ALLOC, 12));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_OLDEST));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_NEWEST));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_ANY));
    // fill the heap exactly, then free above every free chunk
    cmd_q.push_back(mk(OP_INIT));
    cmd_q.push_back(mk(OP_ALLOC, 100));
    cmd_q.push_back(mk(OP_ALLOC, 65420));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_OLDEST));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_NEWEST));
    cmd_q.push_back(mk(OP_INIT));
    cmd_q.push_back(mk(OP_ALLOC, 65528));
    cmd_q.push_back(mk(OP_ALLOC, 4));
    cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_NEWEST));
    cmd_q[20].drain = 1'b1;
    for (int i = 0; i < RAND_ITEMS / 6; i++) cmd_q.push_back(rand_cmd());
    foreach (heap_plan[p]) begin
      wait_idle();
      repeat (4) @(posedge clk);
      cfg_write(REG_HEAP_SIZE, heap_plan[p]);
      @(negedge clk);
      cmd_q.push_back(mk(OP_INIT));
      if (heap_plan[p] == 16) begin
        cmd_q.push_back(mk(OP_ALLOC, 1));
        cmd_q.push_back(mk(OP_ALLOC, 1));
        cmd_q.push_back(mk(OP_FREE, 0, 0, 1, PICK_NEWEST));
      end
      for (int i = 0; i < RAND_ITEMS / 6; i++) cmd_q.push_back(rand_cmd());
    end
    wait_idle();
    repeat (20) @(posedge clk);
    if (resp_q.size() != 0) begin
      $error("%0d results never arrived", resp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
